[src/mrr_pkg.sv]
package mrr_pkg;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQB,
    MUL_SQX
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DECOMP,
    ST_REDUCE,
    ST_POW_TEST,
    ST_POW_ACC,
    ST_POW_SQ,
    ST_CHECK,
    ST_SQ_TEST,
    ST_SQ_WAIT,
    ST_SQ_CHECK,
    ST_FIN_PASS,
    ST_FIN_FAIL
  } state_t;

  typedef struct packed {
    logic    load;
    logic    decomp_shift;
    logic    exp_shift;
    logic    mul_start;
    mul_op_t mul_op;
    logic    r_inc;
    logic    finish;
    logic    pass;
  } cmd_t;

  typedef struct packed {
    logic n_le1;
    logic n_is2;
    logic n_even;
    logic d_lsb;
    logic d_zero;
    logic x_is1;
    logic x_is_nm1;
    logic r_lt_s;
    logic mul_busy;
    logic mul_done;
    logic out_free;
  } status_t;

endpackage

[src/mrr_mulmod.sv]
module mrr_mulmod #(
  parameter int unsigned NUMBER_WIDTH = 31
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] op_x,
  input  logic [NUMBER_WIDTH-1:0] op_y,
  input  logic [NUMBER_WIDTH-1:0] modulus,
  output logic                    busy,
  output logic                    done,
  output logic [NUMBER_WIDTH-1:0] result
);
  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  acc;
  logic [W-1:0]  xo;
  logic [W-1:0]  yo;
  logic [CW-1:0] cnt;

  logic [W:0]   dbl;
  logic [W-1:0] t1;
  logic [W:0]   sum;
  logic [W-1:0] acc_next;

  // one shift-and-add step: acc = 2*acc + bit*x, both reduced mod n
  always_comb begin
    dbl      = {1'b0, acc} + {1'b0, acc};
    t1       = (dbl >= {1'b0, modulus}) ? W'(dbl - {1'b0, modulus}) : dbl[W-1:0];
    sum      = {1'b0, t1} + (yo[W-1] ? {1'b0, xo} : {(W+1){1'b0}});
    acc_next = (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus}) : sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xo  <= op_x;
      yo  <= op_y;
      cnt <= CW'(W - 1);
    end else if (busy) begin
      acc <= acc_next;
      yo  <= {yo[W-2:0], 1'b0};
      cnt <= cnt - CW'(1);
    end
  end

  assign result = acc;

endmodule

[src/mrr_datapath.sv]
module mrr_datapath #(
  parameter int unsigned NUMBER_WIDTH = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  mrr_pkg::cmd_t    cmd,
  output mrr_pkg::status_t status,
  input  logic [30:0]      candidate,
  input  logic [30:0]      witness_base,
  input  logic             last_round,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             round_pass,
  output logic             probably_prime,
  output logic             test_done
);
  import mrr_pkg::*;

  localparam int unsigned W  = NUMBER_WIDTH;
  localparam int unsigned SW = $clog2(W);

  logic [W-1:0]  n;
  logic [W-1:0]  a;
  logic [W-1:0]  d;
  logic [W-1:0]  b;
  logic [W-1:0]  x;
  logic [SW-1:0] s;
  logic [SW-1:0] r;
  logic          last;
  logic          verdict;
  mul_op_t       op_l;

  logic [W-1:0] op_x;
  logic [W-1:0] op_y;
  logic         mul_busy;
  logic         mul_done;
  logic [W-1:0] mul_res;
  logic [W-1:0] nm1;

  assign nm1 = n - W'(1);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_REDUCE: begin
        op_x = W'(1);
        op_y = a;
      end
      MUL_ACC: begin
        op_x = x;
        op_y = b;
      end
      MUL_SQB: begin
        op_x = b;
        op_y = b;
      end
      MUL_SQX: begin
        op_x = x;
        op_y = x;
      end
      default: begin
        op_x = x;
        op_y = x;
      end
    endcase
  end

  mrr_mulmod #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .op_x    (op_x),
    .op_y    (op_y),
    .modulus (n),
    .busy    (mul_busy),
    .done    (mul_done),
    .result  (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= W'(candidate);
      a    <= W'(witness_base);
      d    <= W'(candidate) - W'(1);
      s    <= '0;
      r    <= SW'(1);
      x    <= W'(1);
      last <= last_round;
    end else begin
      if (cmd.decomp_shift) begin
        d <= d >> 1;
        s <= s + SW'(1);
      end
      if (cmd.exp_shift) begin
        d <= d >> 1;
      end
      if (cmd.r_inc) begin
        r <= r + SW'(1);
      end
      if (mul_done) begin
        unique case (op_l) inside
          MUL_REDUCE, MUL_SQB: b <= mul_res;
          MUL_ACC, MUL_SQX:    x <= mul_res;
          default:             x <= mul_res;
        endcase
      end
    end
    if (cmd.mul_start) begin
      op_l <= cmd.mul_op;
    end
  end

  // result register parts the round engine from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      verdict   <= 1'b1;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      verdict   <= last ? 1'b1 : (verdict & cmd.pass);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      round_pass     <= cmd.pass;
      probably_prime <= verdict & cmd.pass;
      test_done      <= last;
    end
  end

  always_comb begin
    status.n_le1    = (n <= W'(1));
    status.n_is2    = (n == W'(2));
    status.n_even   = ~n[0];
    status.d_lsb    = d[0];
    status.d_zero   = (d == '0);
    status.x_is1    = (x == W'(1));
    status.x_is_nm1 = (x == nm1);
    status.r_lt_s   = (r < s);
    status.mul_busy = mul_busy;
    status.mul_done = mul_done;
    status.out_free = ~out_valid | out_ready;
  end

endmodule

[src/mrr_ctrl.sv]
module mrr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mrr_pkg::status_t status,
  output mrr_pkg::cmd_t    cmd
);
  import mrr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = MUL_SQX;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status.n_is2) begin
          state_next = ST_FIN_PASS;
        end else if (status.n_le1 || status.n_even) begin
          state_next = ST_FIN_FAIL;
        end else begin
          state_next = ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (!status.d_lsb) begin
          cmd.decomp_shift = 1'b1;
        end else begin
          // witness reduced mod n as 1 * a through the multiplier
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_REDUCE;
          state_next    = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.mul_done) state_next = ST_POW_TEST;
      end
      ST_POW_TEST: begin
        if (status.d_zero) begin
          state_next = ST_CHECK;
        end else if (status.d_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_ACC;
          state_next    = ST_POW_ACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_SQB;
          state_next    = ST_POW_SQ;
        end
      end
      ST_POW_ACC: begin
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_SQB;
          state_next    = ST_POW_SQ;
        end
      end
      ST_POW_SQ: begin
        if (status.mul_done) begin
          cmd.exp_shift = 1'b1;
          state_next    = ST_POW_TEST;
        end
      end
      ST_CHECK: begin
        if (status.x_is1 || status.x_is_nm1) begin
          state_next = ST_FIN_PASS;
        end else begin
          state_next = ST_SQ_TEST;
        end
      end
      ST_SQ_TEST: begin
        if (status.r_lt_s) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = MUL_SQX;
          cmd.r_inc     = 1'b1;
          state_next    = ST_SQ_WAIT;
        end else begin
          state_next = ST_FIN_FAIL;
        end
      end
      ST_SQ_WAIT: begin
        if (status.mul_done) state_next = ST_SQ_CHECK;
      end
      ST_SQ_CHECK: begin
        state_next = status.x_is_nm1 ? ST_FIN_PASS : ST_SQ_TEST;
      end
      ST_FIN_PASS: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          cmd.pass   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN_FAIL: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/miller_rabin_round.sv]
// channel | signals                                         | direction
// input   | in_valid, in_ready, candidate, witness_base,    | in
//         | last_round                                      |
// output  | out_valid, out_ready, round_pass,               | out
//         | probably_prime, test_done                       |
//
// one item at a time; trivial candidates (n <= 1, even, n == 2) never use the multiplier
// otherwise the shared bit-serial multiplier-reducer sets the cost: each modular
// multiplication works one bit of its second operand at a time, and a round needs 1 + bitlen(d) +
// popcount(d) + up to s - 1 of them, after n - 1 has been split into d * 2^s
// reset (synchronous) empties the result register and sets the running verdict
// a result waiting on out_ready holds the engine in its final state until taken
module miller_rabin_round #(
  parameter int unsigned NUMBER_WIDTH = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] candidate,
  input  logic [30:0] witness_base,
  input  logic        last_round,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        round_pass,
  output logic        probably_prime,
  output logic        test_done
);
  import mrr_pkg::*;

  cmd_t    cmd;
  status_t status;

  mrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mrr_datapath #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .candidate      (candidate),
    .witness_base   (witness_base),
    .last_round     (last_round),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .round_pass     (round_pass),
    .probably_prime (probably_prime),
    .test_done      (test_done)
  );

`ifndef SYNTHESIS
  a_load_idle_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !status.mul_busy)
    else $error("transfer taken while multiplier busy");

  // a chained multiplication may start in the cycle that the previous one reports done
  a_start_idle_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !status.mul_busy)
    else $error("multiplication started while one is in flight");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result written over one not yet taken");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(cmd.finish))
    else $error("output valid without a finished round");
`endif

endmodule

[dv/miller_rabin_round_tb.sv]
module miller_rabin_round_tb;

  localparam int NW          = 31;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 10_000;
  localparam int DRAIN       = 200;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIRECTED  = 24;

  // a directed row either carries its round verdict or leaves it to the predictor
  localparam logic KNOWN = 1'b1;
  localparam logic PRED  = 1'b0;
  localparam logic PASS  = 1'b1;
  localparam logic FAIL  = 1'b0;

  typedef struct packed {
    logic [NW-1:0] cand;
    logic [NW-1:0] wit;
    logic          last;
    logic          known;
    logic          verdict;
  } stim_row_t;

  typedef struct packed {
    logic round_ok;
    logic prime;
    logic done;
  } round_result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [NW-1:0] candidate = '0;
  logic [NW-1:0] witness_base = '0;
  logic          last_round = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          round_pass;
  logic          probably_prime;
  logic          test_done;

  round_result_t pending_verdicts[$];
  logic          kept_verdict = 1'b1;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int err_count   = 0;
  int sent_count  = 0;
  int checked     = 0;
  int passed      = 0;
  int primes_seen = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{31'd0,          31'd5,          1'b0, KNOWN, FAIL},
    '{31'd1,          31'd0,          1'b1, KNOWN, FAIL},
    '{31'd2,          31'h7FFF_FFFF,  1'b1, KNOWN, PASS},
    '{31'd4,          31'd3,          1'b1, KNOWN, FAIL},
    '{31'h7FFF_FFFE,  31'd0,          1'b0, KNOWN, FAIL},
    '{31'd3,          31'd2,          1'b0, KNOWN, PASS},
    '{31'd3,          31'd1,          1'b1, KNOWN, PASS},
    '{31'd3,          31'd3,          1'b1, KNOWN, FAIL},
    '{31'd3,          31'd0,          1'b1, KNOWN, FAIL},
    '{31'h7FFF_FFFF,  31'd1,          1'b0, KNOWN, PASS},
    '{31'h7FFF_FFFF,  31'h7FFF_FFFE,  1'b0, KNOWN, PASS},
    '{31'h7FFF_FFFF,  31'd2,          1'b1, PRED,  FAIL},
    '{31'h7FFF_FFFF,  31'h7FFF_FFFF,  1'b1, KNOWN, FAIL},
    '{31'd561,        31'd2,          1'b1, PRED,  FAIL},
    '{31'd2047,       31'd2,          1'b0, PRED,  FAIL},
    '{31'd2047,       31'd3,          1'b1, PRED,  FAIL},
    '{31'd221,        31'd174,        1'b0, PRED,  FAIL},
    '{31'd221,        31'd137,        1'b1, PRED,  FAIL},
    '{31'd97,         31'd5,          1'b0, PRED,  FAIL},
    '{31'd97,         31'd7,          1'b1, PRED,  FAIL},
    '{31'd25,         31'd7,          1'b1, PRED,  FAIL},
    '{31'd13,         31'h7FFF_FFFF,  1'b1, PRED,  FAIL},
    '{31'd2,          31'd0,          1'b0, KNOWN, PASS},
    '{31'd1,          31'd1,          1'b1, KNOWN, FAIL}
  };

  miller_rabin_round #(.NUMBER_WIDTH(NW)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .candidate      (candidate),
    .witness_base   (witness_base),
    .last_round     (last_round),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .round_pass     (round_pass),
    .probably_prime (probably_prime),
    .test_done      (test_done)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic mr_round_passes(logic [63:0] n, logic [63:0] a);
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] b;
    int          s;
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    // operands stay below 2^31, so the products fit in 64 bits
    x = 1;
    b = a % n;
    while (d != 0) begin
      if (d[0]) x = (x * b) % n;
      b = (b * b) % n;
      d = d >> 1;
    end
    if (x == 1 || x == n - 1) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = (x * x) % n;
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic expect_round(input logic [NW-1:0] c, input logic [NW-1:0] a,
                              input logic l, input logic known, input logic verdict);
    round_result_t r;
    r.round_ok = known ? verdict : mr_round_passes({33'd0, c}, {33'd0, a});
    r.prime    = kept_verdict & r.round_ok;
    r.done     = l;
    kept_verdict = l ? 1'b1 : r.prime;
    pending_verdicts = {pending_verdicts, r};
  endtask

  task automatic offer_round(input logic [NW-1:0] c, input logic [NW-1:0] a,
                             input logic l, input logic known, input logic verdict);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    candidate    <= c;
    witness_base <= a;
    last_round   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    expect_round(c, a, l, known, verdict);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [NW-1:0] pick_candidate();
    logic [NW-1:0] c;
    int            w;
    int            sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      case ($urandom_range(3))
        0:       c = 31'd0;
        1:       c = 31'd1;
        2:       c = 31'd2;
        default: c = NW'($urandom) & 31'h7FFF_FFFE;
      endcase
    end else if (sel < 22) begin
      // primes and strong pseudoprimes, so that whole tests can come out prime
      case ($urandom_range(9))
        0:       c = 31'h7FFF_FFFF;
        1:       c = 31'd65521;
        2:       c = 31'd7919;
        3:       c = 31'd104729;
        4:       c = 31'd2047;
        5:       c = 31'd1373653;
        6:       c = 31'd25326001;
        7:       c = 31'd3;
        8:       c = 31'd5;
        default: c = 31'd7;
      endcase
    end else if (sel < 34) begin
      c = NW'($urandom);
      c[0] = 1'b1;
    end else begin
      // mostly short candidates keep the rounds cheap
      w = $urandom_range(16, 3);
      c = NW'($urandom) & ((31'd1 << w) - 31'd1);
      c[w-1] = 1'b1;
      c[0] = 1'b1;
    end
    return c;
  endfunction

  function automatic logic [NW-1:0] pick_witness(logic [NW-1:0] c);
    logic [NW-1:0] a;
    if (c < 5 || $urandom_range(99) < 20) a = NW'($urandom);
    else a = NW'($urandom_range(c - 2, 2));
    return a;
  endfunction

  task automatic random_tests(input int n_items);
    logic [NW-1:0] c;
    logic          l;
    int            rounds;
    logic          noisy;
    int            done;
    done = 0;
    while (done < n_items) begin
      c      = pick_candidate();
      rounds = $urandom_range(4, 1);
      noisy  = ($urandom_range(99) < 10);
      for (int r = 0; r < rounds && done < n_items; r++) begin
        l = noisy ? 1'($urandom) : (r == rounds - 1 || done == n_items - 1);
        offer_round(c, pick_witness(c), l, PRED, FAIL);
        done++;
      end
    end
  endtask

  task automatic check_result();
    round_result_t e;
    if (pending_verdicts.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("unexpected result: pass=%0b prime=%0b done=%0b", round_pass,
                 probably_prime, test_done);
    end else begin
      e = pending_verdicts.pop_front();
      checked++;
      if (round_pass) passed++;
      if (test_done && probably_prime) primes_seen++;
      if (round_pass !== e.round_ok || probably_prime !== e.prime || test_done !== e.done)
      begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("result %0d mismatch: pass %0b/%0b prime %0b/%0b done %0b/%0b",
                   checked, e.round_ok, round_pass, e.prime, probably_prime, e.done,
                   test_done);
      end
    end
  endtask

  // result side: transfer check, long hold-off on request, random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 22;
    rx_idle_pct = 66;
    for (int i = 0; i < N_DIRECTED; i++)
      offer_round(directed_rows[i].cand, directed_rows[i].wit, directed_rows[i].last,
                  directed_rows[i].known, directed_rows[i].verdict);
    wait_drained();

    random_tests(40);
    wait_drained();

    tx_idle_pct = 66;
    rx_idle_pct = 22;
    random_tests(40);
    wait_drained();

    // receiver stalls for long enough that the engine backs up into the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1;
    random_tests(36);
    wait_drained();

    repeat (DRAIN) @(posedge clk);
    $display("%0d rounds sent (directed and random), %0d results checked", sent_count,
             checked);
    $display("%0d rounds passed, %0d tests ended probably prime", passed, primes_seen);
    if (err_count == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/mrr_pkg.sv
src/mrr_mulmod.sv
src/mrr_datapath.sv
src/mrr_ctrl.sv
src/miller_rabin_round.sv
dv/miller_rabin_round_tb.sv
